// ----- rtl/core/drs_pkg.sv -----
// ----------------------------------------------------------------------------
// drs_pkg
// shared types and constants of the drive strength resolver
// ----------------------------------------------------------------------------
`default_nettype none

package drs_pkg;

	localparam int unsigned StrenW = 8;

	// reset value of the high-z code register
	localparam logic [StrenW-1:0] ZCodeReset = 8'h08;

	// VSSSvsss masks
	localparam logic [StrenW-1:0] MaskV1    = 8'h80;
	localparam logic [StrenW-1:0] MaskHi    = 8'hf0;
	localparam logic [StrenW-1:0] MaskS1    = 8'h70;
	localparam logic [StrenW-1:0] MaskV0    = 8'h08;
	localparam logic [StrenW-1:0] MaskLo    = 8'h0f;
	localparam logic [StrenW-1:0] MaskS0    = 8'h07;
	localparam logic [StrenW-1:0] MaskStren = 8'h77;

	typedef logic [StrenW-1:0] stren_t;

	// running net state
	typedef struct packed {
		stren_t accum;
		logic   skipping;
	} drs_state_t;

	// one registered request
	typedef struct packed {
		logic   first;
		stren_t driver;
		logic   last;
	} drs_req_t;

endpackage

`default_nettype wire

// ----- rtl/core/drive_strength_resolver.sv -----
// ----------------------------------------------------------------------------
// drive_strength_resolver
// resolves the drivers of one net in VSSSvsss strength form
// ----------------------------------------------------------------------------
// Drivers of a net come in one request per cycle, first marking the opening
// driver and last marking the closing one; the resolved value leaves on the
// output channel once per last request. A request is captured in an input
// register and passes the pair-resolution logic against the running
// accumulator; a closing request then lands in the output register, which
// raises out_valid, once that register is free or being taken. The block
// takes one request every cycle: the only loop is the update of the
// accumulator, and the input register keeps accepting while a result waits
// in the output register, stalling only when a closing request meets a full
// output register that is not being taken. cfg_we loads the high-z code
// (reset 0x08), used to spot undriven drivers and to replace zero-strength
// results; write it only while no request is in flight.
`default_nettype none

module drive_strength_resolver import drs_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire stren_t cfg_wdata,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire         first,
	input  wire stren_t driver,
	input  wire         last,
	output logic        out_valid,
	input  wire         out_ready,
	output stren_t      resolved
);

	// high-z code register
	stren_t z_code_q;

	// input stage
	logic       valid_s1;
	drs_req_t   req_s1;

	// running net state
	drs_state_t state_q;
	drs_state_t state_nxt;

	// output stage
	logic       valid_s2;
	stren_t     resolved_s2;

	logic out_free;
	logic adv_s1;

	// a closing request needs the output register, others move freely
	assign out_free = !valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && (!req_s1.last || out_free);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			z_code_q <= ZCodeReset;
		else if (cfg_we)
			z_code_q <= cfg_wdata;
	end

	// capture a request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			req_s1 <= '{first: first, driver: driver, last: last};
	end

	drs_resolve u_resolve (
		.cur    (state_q),
		.req    (req_s1),
		.z_code (z_code_q),
		.nxt    (state_nxt)
	);

	// accumulator and opening-phase flag, reset to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= '0;
		else if (adv_s1)
			state_q <= state_nxt;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv_s1 && req_s1.last)
			valid_s2 <= 1'b1;
		else if (out_ready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && req_s1.last)
			resolved_s2 <= state_nxt.accum;
	end

	assign out_valid = valid_s2;
	assign resolved  = resolved_s2;

	// a closing request always lands its accumulator in the result register
	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && req_s1.last) |=> (out_valid && resolved == $past(state_nxt.accum)))
		else $error("closing request did not load the result register");

	// a stalled closing request blocks new requests
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && req_s1.last && valid_s2 && !out_ready) |-> !in_ready)
		else $error("input accepted while closing request is stalled");

	// net state moves only when a request is applied
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(state_q))
		else $error("net state changed without a request");

	// the accumulator register stays as the state after the closing request
	a_accum_match: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && req_s1.last) |=> (state_q.accum == resolved))
		else $error("result differs from accumulator");

endmodule

`default_nettype wire

// ----- rtl/core/drs_resolve.sv -----
// ----------------------------------------------------------------------------
// drs_resolve
// next-state logic: applies one driver to the running net state
// ----------------------------------------------------------------------------
`default_nettype none

module drs_resolve import drs_pkg::*; (
	input  wire drs_state_t cur,
	input  wire drs_req_t   req,
	input  wire stren_t     z_code,
	output drs_state_t      nxt
);

	function automatic logic unamb(input stren_t x);
		return x[7:4] == x[3:0];
	endfunction

	function automatic stren_t side1(input stren_t x);
		if ((x & MaskV1) != '0)
			return x & MaskHi;
		return stren_t'(MaskS1 - (x & MaskHi));
	endfunction

	function automatic stren_t side0(input stren_t x);
		if ((x & MaskV0) != '0)
			return x & MaskLo;
		return stren_t'(MaskS0 - (x & MaskLo));
	endfunction

	stren_t a, b, r, hi, lo, pair;

	always_comb begin
		a  = cur.accum;
		b  = req.driver;
		r  = a;
		hi = '0;
		lo = '0;
		if (unamb(a) && unamb(b)) begin
			if (a == b)
				r = a;
			else if ((b & MaskS0) > (a & MaskS0))
				r = b;
			else if ((b & MaskStren) == (a & MaskStren))
				r = (a & MaskS1) | (b & MaskS0) | MaskV1;
			else
				r = a;
		end else if (unamb(a) || unamb(b)) begin
			// each nibble from the stronger side, driver wins ties
			hi = ((a & MaskS1) > (b & MaskS1)) ? (a & MaskHi) : (b & MaskHi);
			lo = ((a & MaskS0) > (b & MaskS0)) ? (a & MaskLo) : (b & MaskLo);
			r  = hi | lo;
		end else begin
			// widen the ambiguous range
			hi = (side1(b) > side1(a)) ? (b & MaskHi) : (a & MaskHi);
			lo = (side0(b) < side0(a)) ? (b & MaskLo) : (a & MaskLo);
			r  = hi | lo;
		end
		if ((r & MaskStren) == '0)
			r = z_code;
		pair = (b == z_code) ? a : r;

		if (req.first || cur.skipping) begin
			nxt.accum    = b;
			nxt.skipping = (b == z_code);
		end else begin
			nxt.accum    = pair;
			nxt.skipping = 1'b0;
		end
	end

endmodule

`default_nettype wire

// ----- dv/drive_strength_resolver_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drive_strength_resolver_test
// self-checking bench for the net strength resolver
// ----------------------------------------------------------------------------
// Drivers of a net are sent as requests with random gaps, and the receiver
// stalls at random. A strength-resolution model in the bench keeps its own
// accumulator, skip flag and high-z code. It queues one resolved value for
// every closing request, and each result that leaves the block is checked
// against the oldest queued value. The run covers directed pair rules,
// several high-z codes (extremes too), long random nets with some malformed
// ones, a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------

module drive_strength_resolver_test;
	import drs_pkg::*;

	localparam int unsigned CycleLimit   = 1_000_000;
	localparam int          SettleCycles = 8;

	// ways a random net can be malformed
	typedef enum int {
		NetClean,
		NetNoFirst,
		NetNoLast,
		NetRestart,
		NetEarlyLast
	} net_flaw_e;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// block inputs, all known from time zero
	logic   cfg_we    = 1'b0;
	stren_t cfg_wdata = '0;
	logic   in_valid  = 1'b0;
	logic   first     = 1'b0;
	stren_t driver    = '0;
	logic   last      = 1'b0;
	logic   out_ready = 1'b0;

	// block outputs
	logic   in_ready;
	logic   out_valid;
	stren_t resolved;

	// strength model state, kept apart from the block
	stren_t zcode_model   = ZCodeReset;
	stren_t net_accum     = '0;
	logic   net_skipping  = 1'b0;
	stren_t pending_resolved[$];

	int unsigned cycle_count  = 0;
	int          error_count  = 0;
	int          drivers_sent = 0;
	// both sides insert gaps only while this is set
	logic        idle_mode    = 1'b1;
	// a long receiver hold-off, picked up by the receiver process
	int          hold_cycles  = 0;

	drive_strength_resolver uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.first     (first),
		.driver    (driver),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.resolved  (resolved)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------------
	// strength model
	// ------------------------------------------------------------------------

	// strength of the one side, 0x70 minus the high nibble when the one value is clear
	function automatic stren_t one_side_stren(input stren_t x);
		if (x[7])
			return x & MaskHi;
		return MaskS1 - (x & MaskHi);
	endfunction

	// strength of the zero side, 0x07 minus the low nibble when the zero value is clear
	function automatic stren_t zero_side_stren(input stren_t x);
		if (x[3])
			return x & MaskLo;
		return MaskS0 - (x & MaskLo);
	endfunction

	// resolve one driver against the running net value
	function automatic stren_t resolve_pair(input stren_t a, input stren_t b);
		stren_t r;
		stren_t hi;
		stren_t lo;
		logic   a_clear;
		logic   b_clear;
		a_clear = (a[7:4] == a[3:0]);
		b_clear = (b[7:4] == b[3:0]);
		// an undriven driver leaves the net alone, no canonical form
		if (b == zcode_model)
			return a;
		r = a;
		if (a_clear && b_clear) begin
			if (a == b)
				r = a;
			else if ((b & MaskS0) > (a & MaskS0))
				r = b;
			else if ((b & MaskStren) == (a & MaskStren))
				r = (a & MaskS1) | (b & MaskS0) | MaskV1; // equal strength, opposite value
			else
				r = a;
		end else if (a_clear || b_clear) begin
			// each nibble from the stronger side, ties go to the driver
			hi = ((a & MaskS1) > (b & MaskS1)) ? (a & MaskHi) : (b & MaskHi);
			lo = ((a & MaskS0) > (b & MaskS0)) ? (a & MaskLo) : (b & MaskLo);
			r  = hi | lo;
		end else begin
			// both ambiguous: widen the range
			hi = (one_side_stren(b) > one_side_stren(a)) ? (b & MaskHi) : (a & MaskHi);
			lo = (zero_side_stren(b) < zero_side_stren(a)) ? (b & MaskLo) : (a & MaskLo);
			r  = hi | lo;
		end
		// no strength left on either side: canonical high-z
		if ((r & MaskStren) == '0)
			r = zcode_model;
		return r;
	endfunction

	// advance the model by one accepted request
	task automatic apply_driver(input logic is_first, input stren_t drv, input logic is_last);
		if (is_first || net_skipping) begin
			net_accum    = drv;
			net_skipping = (drv == zcode_model);
		end else begin
			net_accum = resolve_pair(net_accum, drv);
		end
		if (is_last)
			pending_resolved.push_back(net_accum);
		drivers_sent++;
	endtask

	// ------------------------------------------------------------------------
	// random helpers
	// ------------------------------------------------------------------------

	// idle length: mostly none, some short, a few long
	function automatic int idle_gap();
		int roll;
		if (!idle_mode)
			return 0;
		roll = $urandom_range(99);
		if (roll < 70)
			return 0;
		if (roll < 96)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// driver values weighted toward the interesting classes
	function automatic stren_t pick_driver();
		int         roll;
		logic [3:0] nib;
		roll = $urandom_range(99);
		nib  = 4'($urandom);
		if (roll < 20)
			return zcode_model;
		if (roll < 50)
			return {nib, nib};          // unambiguous
		if (roll < 60) begin
			case ($urandom_range(5))
				0: return 8'h00;
				1: return 8'hff;
				2: return 8'h80;
				3: return 8'h08;
				4: return 8'h77;
				default: return 8'hf7;
			endcase
		end
		return stren_t'($urandom);
	endfunction

	// net sizes: mostly short, some medium, a few long
	function automatic int net_length();
		int roll;
		roll = $urandom_range(99);
		if (roll < 60)
			return $urandom_range(3, 1);
		if (roll < 90)
			return $urandom_range(8, 4);
		return $urandom_range(16, 9);
	endfunction

	// ------------------------------------------------------------------------
	// mismatch reporting and result checking
	// ------------------------------------------------------------------------

	task automatic log_mismatch(input string what, input stren_t got, input stren_t want);
		$display("[%0t] MISMATCH %s: got %02h want %02h", $realtime, what, got, want);
		error_count++;
	endtask

	// every accepted result is matched against the oldest queued value
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_resolved.size() == 0)
				log_mismatch("result with no request pending", resolved, '0);
			else if (resolved !== pending_resolved[0]) begin
				log_mismatch("resolved", resolved, pending_resolved[0]);
				void'(pending_resolved.pop_front());
			end else
				void'(pending_resolved.pop_front());
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// receiver: random stalls, plus a long hold-off when asked for
	// ------------------------------------------------------------------------
	initial begin : result_sink
		int idle_left;
		idle_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_cycles != 0) begin
				idle_left   = hold_cycles;
				hold_cycles = 0;
			end
			if (idle_left > 0) begin
				out_ready <= 1'b0;
				idle_left--;
			end else begin
				idle_left = idle_gap();
				if (idle_left > 0) begin
					out_ready <= 1'b0;
					idle_left--;
				end else
					out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// sender side
	// ------------------------------------------------------------------------

	// offer one request, hold it until taken, then maybe idle; valid stays
	// high into the next request when there is no gap
	task automatic send_driver(input logic is_first, input stren_t drv, input logic is_last);
		int gap;
		first    <= is_first;
		driver   <= drv;
		last     <= is_last;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		apply_driver(is_first, drv, is_last);
		gap = idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering and wait for every result, then let the pipe empty
	task automatic drain_block();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_resolved.size() != 0);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// high-z code write, only with the block idle
	task automatic write_z_code(input stren_t code);
		drain_block();
		cfg_we    <= 1'b1;
		cfg_wdata <= code;
		@(posedge clk);
		cfg_we      <= 1'b0;
		zcode_model  = code;
	endtask

	// one net of random drivers, possibly malformed
	task automatic send_net(input int n, input net_flaw_e flaw);
		int cut;
		cut = $urandom_range(n - 1);
		for (int i = 0; i < n; i++) begin
			send_driver((i == 0 && flaw != NetNoFirst) || (i == cut && flaw == NetRestart),
				pick_driver(),
				(i == n - 1 && flaw != NetNoLast) || (i == cut && flaw == NetEarlyLast));
		end
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// requests straight after reset, before any opening driver
	task automatic test_after_reset();
		send_driver(1'b0, 8'h35, 1'b1);   // combines with the reset accumulator
		send_driver(1'b1, 8'h08, 1'b1);   // first and last at once, high-z kept as is
		send_driver(1'b0, 8'h00, 1'b1);   // replaces the high-z accumulator
		send_driver(1'b1, 8'hff, 1'b1);
	endtask

	// each pair rule and the opening-phase cases
	task automatic test_pair_rules();
		// equal, then equal strength with opposite value
		send_driver(1'b1, 8'h66, 1'b0);
		send_driver(1'b0, 8'h66, 1'b0);
		send_driver(1'b0, 8'hee, 1'b1);
		// stronger driver wins, weaker one is dropped
		send_driver(1'b1, 8'h55, 1'b0);
		send_driver(1'b0, 8'h77, 1'b1);
		send_driver(1'b1, 8'hff, 1'b0);
		send_driver(1'b0, 8'h33, 1'b1);
		// exactly one ambiguous side
		send_driver(1'b1, 8'h44, 1'b0);
		send_driver(1'b0, 8'hb6, 1'b1);
		// both ambiguous
		send_driver(1'b1, 8'ha3, 1'b0);
		send_driver(1'b0, 8'h5c, 1'b1);
		// opening phase: high-z drivers keep being replaced
		send_driver(1'b1, 8'h08, 1'b0);
		send_driver(1'b0, 8'h08, 1'b0);
		send_driver(1'b0, 8'h2a, 1'b0);
		send_driver(1'b0, 8'h08, 1'b1);   // undriven driver leaves the net alone
		// zero strength turns into high-z, and does not reopen the net
		send_driver(1'b1, 8'h00, 1'b0);
		send_driver(1'b0, 8'h80, 1'b0);
		send_driver(1'b0, 8'h33, 1'b0);
		send_driver(1'b0, 8'h11, 1'b1);
		// more drivers after last continue the same net
		send_driver(1'b0, 8'h22, 1'b1);
	endtask

	// random nets, some malformed, with stretches where nobody idles
	task automatic test_random_nets(input int count);
		int        start;
		int        roll;
		net_flaw_e flaw;
		start = drivers_sent;
		while (drivers_sent - start < count) begin
			if ($urandom_range(49) == 0)
				idle_mode = !idle_mode;
			roll = $urandom_range(99);
			flaw = NetClean;
			if (roll >= 88)
				flaw = net_flaw_e'($urandom_range(4, 1));
			send_net(net_length(), flaw);
		end
		idle_mode = 1'b1;
	endtask

	// receiver holds off for a long stretch while requests keep coming, so
	// the block fills and stalls its input
	task automatic test_output_hold();
		idle_mode   = 1'b0;
		hold_cycles = 300;
		for (int i = 0; i < 40; i++)
			send_net($urandom_range(2, 1), NetClean);
		idle_mode = 1'b1;
	endtask

	// sender stops until every result is back, then resumes mid-stream
	task automatic test_sender_pause();
		for (int i = 0; i < 10; i++)
			send_net(net_length(), NetClean);
		drain_block();
		for (int i = 0; i < 10; i++)
			send_net(net_length(), NetClean);
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_pair_rules();
		test_random_nets(450);

		// high-z code at its extremes, at a random value and at 0x77
		write_z_code(8'h00);
		test_random_nets(200);
		write_z_code(8'hff);
		test_random_nets(200);
		write_z_code(stren_t'($urandom));
		test_random_nets(200);
		write_z_code(8'h77);
		test_random_nets(100);
		write_z_code(ZCodeReset);

		test_output_hold();
		test_sender_pause();
		test_random_nets(250);

		// wait out every result and the pipeline latency
		drain_block();
		if (pending_resolved.size() != 0)
			log_mismatch("results never arrived", '0, pending_resolved[0]);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
